// File: rtl/pctd_pkg.sv
// pctd_pkg: shared types and constants of the prefix-code table decoder.
// No dependencies; pctd_ctrl, pctd_datapath and the core import it.
`default_nettype none

package pctd_pkg;

    localparam int SYM_W   = 8;
    localparam int ELEN_W  = 6;
    localparam int ECODE_W = 32;
    localparam int OP_W    = 2;

    // Item operations
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_BIT   = 2'd2;

    // Result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NOMATCH = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [SYM_W-1:0]   entry_symbol;
        logic [ELEN_W-1:0]  entry_length;
        logic [ECODE_W-1:0] entry_code;
        logic               code_bit;
    } pctd_in_t;

    typedef struct packed {
        logic [SYM_W-1:0] decoded_symbol;
        logic             status;
    } pctd_out_t;

    // Controller to datapath
    typedef struct packed {
        logic take;          // latch the incoming beat, restart the scan
        logic clear_table;
        logic shift_bit;
        logic scan_step;
        logic write_hit;     // overwrite the matched entry
        logic write_new;     // append at entry_count
        logic result_match;
        logic result_error;
        logic out_load;
    } pctd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic len_ok;
        logic table_full;
        logic scan_hit;
        logic scan_done;
        logic scan_enable;
        logic acc_full;
        logic out_free;
    } pctd_stat_t;

endpackage

`default_nettype wire

// File: rtl/pctd_ram.sv
// pctd_ram: generic simple dual-port RAM, one write and one registered read.
// Depends on nothing.
`default_nettype none

module pctd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/pctd_ctrl.sv
// pctd_ctrl: sequencing state machine of the prefix-code table decoder.
// Depends on pctd_pkg; drives pctd_datapath through pctd_cmd_t.
`default_nettype none

module pctd_ctrl
    import pctd_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [OP_W-1:0] in_op,
    input  wire pctd_stat_t      stat,
    output pctd_cmd_t            cmd
);

    localparam logic [1:0] S_IDLE      = 2'd0;
    localparam logic [1:0] S_LOAD_SCAN = 2'd1;
    localparam logic [1:0] S_BIT_SCAN  = 2'd2;
    localparam logic [1:0] S_EMIT      = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take = 1'b1;
                    unique case (in_op)
                        OP_CLEAR: cmd.clear_table = 1'b1;
                        OP_LOAD:  state_next = S_LOAD_SCAN;
                        OP_BIT: begin
                            cmd.shift_bit = 1'b1;
                            state_next    = S_BIT_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_LOAD_SCAN: begin
                if (!stat.len_ok) begin
                    state_next = S_IDLE;
                end else if (stat.scan_hit) begin
                    cmd.write_hit = 1'b1;
                    state_next    = S_IDLE;
                end else if (stat.scan_done) begin
                    cmd.write_new = !stat.table_full;
                    state_next    = S_IDLE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_BIT_SCAN: begin
                if (stat.scan_enable && stat.scan_hit) begin
                    cmd.result_match = 1'b1;
                    state_next       = S_EMIT;
                end else if (!stat.scan_enable || stat.scan_done) begin
                    if (stat.acc_full) begin
                        cmd.result_error = 1'b1;
                        state_next       = S_EMIT;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/pctd_datapath.sv
// pctd_datapath: code table RAM, bit accumulator, scan pointer and result register.
// Depends on pctd_pkg and pctd_ram; commanded by pctd_ctrl.
`default_nettype none

module pctd_datapath
    import pctd_pkg::*;
#(
    parameter int TABLE_DEPTH  = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire pctd_in_t   s_data,
    input  wire pctd_cmd_t  cmd,
    output pctd_stat_t      stat,
    output logic            m_valid,
    input  wire logic       m_ready,
    output pctd_out_t       m_data
);

    localparam int IW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int LW   = $clog2(MAX_CODE_LEN + 1);
    localparam int CMPW = (LW > ELEN_W) ? LW : ELEN_W;
    localparam int WW   = SYM_W + ELEN_W + MAX_CODE_LEN;

    // Latched item
    logic [OP_W-1:0]         op_reg;
    logic [SYM_W-1:0]        sym_reg;
    logic [ELEN_W-1:0]       len_reg;
    logic [MAX_CODE_LEN-1:0] code_reg;

    logic [CW-1:0]           count_reg;
    logic [LW-1:0]           shortest_reg;
    logic [MAX_CODE_LEN-1:0] acc_reg;
    logic [LW-1:0]           acc_len_reg;

    logic [CW-1:0]           idx_reg;
    logic                    pend_reg;
    logic [IW-1:0]           pend_idx_reg;

    logic [SYM_W-1:0]        res_sym_reg;
    logic                    res_status_reg;
    logic                    m_valid_reg;
    pctd_out_t               m_data_reg;

    // Incoming code masked to its length, widened to 64 bits
    logic [ECODE_W:0]        mask_wide;
    logic [63:0]             code_ext;

    logic                    rd_en;
    logic                    wr_en;
    logic [IW-1:0]           wr_addr;
    logic [WW-1:0]           wr_word;
    logic [WW-1:0]           rd_word;
    logic [SYM_W-1:0]        rd_sym;
    logic [ELEN_W-1:0]       rd_len;
    logic [MAX_CODE_LEN-1:0] rd_code;
    logic                    match;

    assign mask_wide = ((ECODE_W + 1)'(1) << s_data.entry_length) - (ECODE_W + 1)'(1);
    assign code_ext  = {32'd0, s_data.entry_code & mask_wide[ECODE_W-1:0]};

    assign rd_sym  = rd_word[WW-1 -: SYM_W];
    assign rd_len  = rd_word[MAX_CODE_LEN + ELEN_W - 1 -: ELEN_W];
    assign rd_code = rd_word[MAX_CODE_LEN-1:0];

    always_comb begin
        if (op_reg == OP_LOAD) begin
            match = (rd_sym == sym_reg);
        end else begin
            match = (CMPW'(rd_len) == CMPW'(acc_len_reg)) && (rd_code == acc_reg);
        end
    end

    assign rd_en   = cmd.scan_step && (idx_reg < count_reg);
    assign wr_en   = cmd.write_hit || cmd.write_new;
    assign wr_addr = cmd.write_hit ? pend_idx_reg : count_reg[IW-1:0];
    assign wr_word = {sym_reg, len_reg, code_reg};

    pctd_ram #(
        .WIDTH (WW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_word),
        .re    (rd_en),
        .raddr (idx_reg[IW-1:0]),
        .rdata (rd_word)
    );

    always_comb begin
        stat.len_ok      = (len_reg != '0) &&
                           (CMPW'(len_reg) <= CMPW'(MAX_CODE_LEN));
        stat.table_full  = (count_reg == CW'(TABLE_DEPTH));
        stat.scan_hit    = pend_reg && match;
        stat.scan_done   = !pend_reg && (idx_reg >= count_reg);
        stat.scan_enable = (acc_len_reg >= shortest_reg);
        stat.acc_full    = (acc_len_reg == LW'(MAX_CODE_LEN));
        stat.out_free    = !m_valid_reg || m_ready;
    end

    // Item latch, result capture and payload registers
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            op_reg   <= s_data.op;
            sym_reg  <= s_data.entry_symbol;
            len_reg  <= s_data.entry_length;
            code_reg <= code_ext[MAX_CODE_LEN-1:0];
        end
        if (rd_en) begin
            pend_idx_reg <= idx_reg[IW-1:0];
        end
        if (cmd.result_match) begin
            res_sym_reg    <= rd_sym;
            res_status_reg <= STATUS_OK;
        end else if (cmd.result_error) begin
            res_sym_reg    <= '0;
            res_status_reg <= STATUS_NOMATCH;
        end
        if (cmd.out_load) begin
            m_data_reg.decoded_symbol <= res_sym_reg;
            m_data_reg.status         <= res_status_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            shortest_reg <= LW'(MAX_CODE_LEN);
            acc_reg      <= '0;
            acc_len_reg  <= '0;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.take) begin
                idx_reg  <= '0;
                pend_reg <= 1'b0;
            end else if (cmd.scan_step) begin
                pend_reg <= rd_en;
                if (rd_en) begin
                    idx_reg <= idx_reg + CW'(1);
                end
            end

            if (cmd.clear_table) begin
                count_reg    <= '0;
                shortest_reg <= LW'(MAX_CODE_LEN);
            end else if (wr_en) begin
                if (cmd.write_new) begin
                    count_reg <= count_reg + CW'(1);
                end
                if (CMPW'(len_reg) < CMPW'(shortest_reg)) begin
                    shortest_reg <= LW'(len_reg);
                end
            end

            if (cmd.clear_table || cmd.result_match || cmd.result_error) begin
                acc_reg     <= '0;
                acc_len_reg <= '0;
            end else if (cmd.shift_bit) begin
                acc_reg     <= {acc_reg[MAX_CODE_LEN-2:0], s_data.code_bit};
                acc_len_reg <= acc_len_reg + LW'(1);
            end

            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// File: rtl/prefix_code_table_decoder_core.sv
// prefix_code_table_decoder_core: top level of the table-driven prefix-code decoder.
// Depends on pctd_pkg, pctd_ctrl, pctd_datapath and pctd_ram.
//
//   channel   dir   handshake           payload      meaning
//   s_        in    s_valid / s_ready   pctd_in_t    clear, load entry or one code bit
//   m_        out   m_valid / m_ready   pctd_out_t   decoded symbol or no-match status
//
// Timing: a clear beat needs no table scan; a load beat scans the table for its symbol;
//   a bit beat scans the table only once the accumulator holds at least as many bits
//   as the shortest loaded code. Beat length is set by the table scan, one RAM entry
//   read per cycle through a single read port.
// Reset: aresetn is synchronous, active low; it empties the table and the accumulator.
//   The table RAM itself is not cleared, only entries below entry_count are read.
// Stalls: a new beat is taken while an earlier result waits in the output register;
//   a bit beat that produces a result holds in its last state until that register frees.
`default_nettype none

module prefix_code_table_decoder_core
    import pctd_pkg::*;
#(
    parameter int TABLE_DEPTH  = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire pctd_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output pctd_out_t      m_data
);

    pctd_cmd_t  cmd;
    pctd_stat_t stat;

    // Sequence each beat: dispatch on op, walk the table, hand off the result
    pctd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .in_op   (s_data.op),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Hold the table, the accumulator and the output register
    pctd_datapath #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Never overwrite a result still waiting for the sink
    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over an unconsumed beat");

    // Append only while the table has room
    a_write_new_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write_new |-> !stat.table_full)
        else $error("append to a full table");

    // Flag no-match only with a full accumulator
    a_error_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.result_error |-> stat.acc_full)
        else $error("no-match flagged below maximum length");

    // A decision empties the accumulator and blocks input until handed off
    a_result_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.result_match || cmd.result_error) |=> (!s_ready && !stat.acc_full))
        else $error("accumulator not cleared after a result");

endmodule

`default_nettype wire
